### sv/sobel_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
package sobel_pkg;
   localparam int MaxLine   = 2048;
   localparam int AddrBits  = 11;
   localparam int ColBits   = 12;
   localparam int RowBits   = 13;
   localparam int PixelBits = 8;
   localparam int SqBits    = 17;
   localparam int GradBits  = 11;
   localparam logic [ColBits-1:0] WidthReset = 12'd640;
   localparam logic [RowBits-1:0] RowsReset  = 13'd480;
   localparam logic [0:0] CsrLineWidth = 1'b0;
   localparam logic [0:0] CsrFrameRows = 1'b1;

   typedef struct packed {
      logic load;
      logic root_step;
      logic [2:0] root_bit;
   } cmd_type;

   typedef struct packed {
      logic has_result;
   } stat_type;
endpackage

### sv/sobel_ctrl.sv
// Controller FSM: sequences pixel load, square root iterations and result handoff.
module sobel_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              out_busy,
   input  sobel_pkg::stat_type stat,
   output sobel_pkg::cmd_type  cmd,
   output logic              rsp_load
);
   typedef enum logic [1:0] {ST_IDLE, ST_GRAD, ST_ROOT, ST_DONE} state_type;
   state_type state_ff;
   logic [2:0] bit_ff;

   assign req_tready   = (state_ff == ST_IDLE);
   assign cmd.load     = req_tvalid && req_tready;
   assign cmd.root_step = (state_ff == ST_ROOT);
   assign cmd.root_bit = bit_ff;
   assign rsp_load     = (state_ff == ST_DONE) && !out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= 3'd7;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               bit_ff <= 3'd7;
               if (cmd.load) state_ff <= ST_GRAD;
            end
            ST_GRAD: begin
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (bit_ff == 3'd0) state_ff <= stat.has_result ? ST_DONE : ST_IDLE;
               bit_ff <= bit_ff - 3'd1;
            end
            ST_DONE: begin
               if (!out_busy) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

### sv/sobel_dp.sv
// Datapath: line stores, window, counters, gradients and bitwise square root.
module sobel_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [0:0]                       csr_index,
   input  logic [sobel_pkg::RowBits-1:0]    csr_wdata,
   input  logic [7:0]                       pixel,
   input  sobel_pkg::cmd_type               cmd,
   output sobel_pkg::stat_type              stat,
   output logic [7:0]                       magnitude,
   output logic                             frame_last
);
   localparam int AB = sobel_pkg::AddrBits;
   localparam int GradBits = sobel_pkg::GradBits;
   logic [7:0] mid_mem [sobel_pkg::MaxLine];
   logic [7:0] top_mem [sobel_pkg::MaxLine];
   logic [7:0] mid_rd, top_rd;
   logic [AB-1:0] addr_ff;
   logic [7:0] w00_ff, w01_ff, w10_ff, w11_ff, w20_ff, w21_ff;
   logic [sobel_pkg::ColBits-1:0] width_ff, eff_w;
   logic [sobel_pkg::RowBits-1:0] rows_ff, eff_r;
   logic [AB-1:0] col_ff, col;
   logic [sobel_pkg::ColBits-1:0] row_ff, row;
   logic [7:0] px_ff;
   logic phase_ff;          // 1: memory read data valid, window update pending
   logic has_ff, last_ff;
   logic [sobel_pkg::SqBits-1:0] sq_ff;
   logic [7:0] root_ff;
   logic signed [sobel_pkg::GradBits-1:0] gx, gy;
   logic [9:0] ax, ay;
   logic [20:0] sum;
   logic [7:0] trial;
   logic [15:0] tsq;

   always_comb begin
      eff_w = width_ff;
      if (width_ff < 12'd3) eff_w = 12'd3;
      if (width_ff > 12'(sobel_pkg::MaxLine)) eff_w = 12'(sobel_pkg::MaxLine);
      eff_r = rows_ff;
      if (rows_ff < 13'd3) eff_r = 13'd3;
      if (rows_ff > 13'd4096) eff_r = 13'd4096;
      col = ({1'b0, col_ff} >= eff_w) ? AB'(eff_w - 12'd1) : col_ff;
      row = ({1'b0, row_ff} >= eff_r) ? 12'(eff_r - 13'd1) : row_ff;
   end

   // Read at load, consume in the next cycle (gradient cycle).
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mid_rd  <= mid_mem[col];
         top_rd  <= top_mem[col];
         addr_ff <= col;
      end
      if (phase_ff) begin
         mid_mem[addr_ff] <= px_ff;
         top_mem[addr_ff] <= mid_rd;
      end
   end

   always_comb begin
      gx = GradBits'($signed({3'b0, top_rd})) + (GradBits'($signed({3'b0, mid_rd})) <<< 1)
         + GradBits'($signed({3'b0, px_ff})) - GradBits'($signed({3'b0, w00_ff}))
         - (GradBits'($signed({3'b0, w10_ff})) <<< 1) - GradBits'($signed({3'b0, w20_ff}));
      gy = GradBits'($signed({3'b0, w00_ff})) + (GradBits'($signed({3'b0, w01_ff})) <<< 1)
         + GradBits'($signed({3'b0, top_rd})) - GradBits'($signed({3'b0, w20_ff}))
         - (GradBits'($signed({3'b0, w21_ff})) <<< 1) - GradBits'($signed({3'b0, px_ff}));
      ax = 10'(gx[GradBits-1] ? -gx : gx);
      ay = 10'(gy[GradBits-1] ? -gy : gy);
      sum = (21'(ax) * 21'(ax)) + (21'(ay) * 21'(ay));
      trial = root_ff | (8'd1 << cmd.root_bit);
      tsq = 16'(trial) * 16'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sobel_pkg::WidthReset;
         rows_ff  <= sobel_pkg::RowsReset;
         col_ff <= '0;
         row_ff <= '0;
         phase_ff <= 1'b0;
         has_ff <= 1'b0;
         w00_ff <= '0; w01_ff <= '0; w10_ff <= '0;
         w11_ff <= '0; w20_ff <= '0; w21_ff <= '0;
      end else begin
         phase_ff <= cmd.load;
         if (cmd.load) begin
            px_ff   <= pixel;
            has_ff  <= (row >= 12'd2) && (col >= AB'(2));
            last_ff <= ({1'b0, row} == 13'(eff_r - 13'd1))
                       && ({1'b0, col} == 12'(eff_w - 12'd1));
            if ({1'b0, col} + 12'd1 >= eff_w) begin
               col_ff <= '0;
               row_ff <= ({1'b0, row} + 13'd1 >= eff_r) ? '0 : row + 12'd1;
            end else begin
               col_ff <= col + AB'(1);
               row_ff <= row;
            end
         end
         if (phase_ff) begin
            sq_ff   <= (sum >= 21'd65536) ? '1 : 17'(sum);
            root_ff <= (sum >= 21'd65536) ? 8'hFF : 8'd0;
            w00_ff <= w01_ff; w10_ff <= w11_ff; w20_ff <= w21_ff;
            w01_ff <= top_rd; w11_ff <= mid_rd; w21_ff <= px_ff;
         end else if (cmd.root_step && !sq_ff[16]) begin
            if ({1'b0, tsq} <= sq_ff) root_ff <= trial;
         end
         if (csr_we) begin
            if (csr_index == sobel_pkg::CsrLineWidth) width_ff <= csr_wdata[11:0];
            else width_ff <= width_ff;
            if (csr_index == sobel_pkg::CsrFrameRows) rows_ff <= csr_wdata;
            col_ff <= '0;
            row_ff <= '0;
         end
      end
   end

   assign stat.has_result = has_ff;
   assign magnitude  = root_ff;
   assign frame_last = last_ff;
endmodule

### sv/sobel_edge_magnitude_top.sv
// Sobel 3x3 gradient magnitude: top level with result register.
// A req transaction reaches rsp_tvalid through the gradient step, 8 root steps and the handoff.
// The block takes no new pixel until the bit-serial root unit has finished the last one;
// a result held by rsp_tready low stalls the next pixel for as long as it waits.
// The root unit resolves one result bit per cycle, most significant first.
// Reset: synchronous, active high; clears counters, window and registers to 640 x 480.
// Line stores are not cleared; they are written before any result reads them.
module sobel_edge_magnitude_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] magnitude
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   sobel_pkg::cmd_type  cmd;
   sobel_pkg::stat_type stat;
   logic       rsp_load;
   logic [7:0] mag;
   logic       last;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   sobel_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .out_busy(rsp_valid_ff && !rsp_tready),
      .stat, .cmd, .rsp_load
   );

   sobel_dp u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .pixel(req_tdata), .cmd, .stat, .magnitude(mag), .frame_last(last)
   );

   // Output register: holds a finished transaction while the next pixel is worked.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= mag;
         rsp_last_ff  <= last;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp data changed while stalled");
   a_noload_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result loaded over pending transaction");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second pixel taken during work");
endmodule

### tb/sobel_edge_magnitude_top_tb.sv
// Self-checking testbench for the Sobel gradient magnitude block.
module sobel_edge_magnitude_top_tb;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] pixel
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] magnitude
   logic        rsp_tlast;   // frame_last
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [12:0] csr_wdata;

   typedef struct packed {
      logic [7:0] magnitude;
      logic       frame_last;
   } edge_result_type;

   // Predictor state: two row banks, 3x2 window, position, registers.
   logic [7:0]  row1_bank [sobel_pkg::MaxLine];
   logic [7:0]  row2_bank [sobel_pkg::MaxLine];
   logic [7:0]  win [3][2];
   int unsigned col_pos;
   int unsigned row_pos;
   logic [11:0] width_reg;
   logic [12:0] rows_reg;

   edge_result_type pending_edges[$];
   int          error_count;
   int          pixels_sent;
   int          edges_seen;
   int          frames_seen;
   bit          done;
   int          rsp_stall;

   sobel_edge_magnitude_top DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Floor square root saturated at 255.
   function automatic logic [7:0] sat_root(longint unsigned v);
      int unsigned root;
      int unsigned t;
      root = 0;
      if (v >= 65536) return 8'd255;
      for (int b = 7; b >= 0; b--) begin
         t = root | (1 << b);
         if (longint'(t) * t <= v) root = t;
      end
      return root[7:0];
   endfunction

   // Advance the predictor by one pixel; queue the magnitude if interior.
   task automatic predict_magnitude(logic [7:0] px);
      int unsigned w, r, c, rw;
      logic [7:0] top, mid;
      int gx, gy;
      edge_result_type res;
      w = (width_reg < 3) ? 3 : ((width_reg > sobel_pkg::MaxLine) ? sobel_pkg::MaxLine
                                                                  : width_reg);
      rw = (rows_reg < 3) ? 3 : ((rows_reg > 4096) ? 4096 : rows_reg);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= rw) ? rw - 1 : row_pos;
      mid = row1_bank[c];
      top = row2_bank[c];
      if (r >= 2 && c >= 2) begin
         gx = (int'(top) + 2 * int'(mid) + int'(px))
            - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
         gy = (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(top))
            - (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(px));
         res.magnitude  = sat_root(longint'(gx) * gx + longint'(gy) * gy);
         res.frame_last = (r == rw - 1 && c == w - 1);
         pending_edges.insert(pending_edges.size(), res);
      end
      for (int i = 0; i < 3; i++) win[i][0] = win[i][1];
      win[0][1] = top;
      win[1][1] = mid;
      win[2][1] = px;
      row2_bank[c] = mid;
      row1_bank[c] = px;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= rw) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // Valid stays up across back-to-back transactions; it drops only for a gap or a drain.
   task automatic send_pixel(logic [7:0] px);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;   // stretches without gaps
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      predict_magnitude(px);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);   // a no-result pixel may still be in flight
   endtask

   // Register write while idle; restarts the frame position.
   task automatic write_csr(logic [0:0] idx, logic [12:0] val);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sobel_pkg::CsrLineWidth) width_reg = val[11:0];
      else rows_reg = val;
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic send_frame(int unsigned w, int unsigned r, int mode);
      for (int i = 0; i < w * r; i++) begin
         case (mode)
            0: send_pixel(8'($urandom_range(0, 255)));
            1: send_pixel(((i % w) < w / 2) ? 8'd0 : 8'd255);   // vertical step
            2: send_pixel(((i / w) % 2) ? 8'd255 : 8'd0);       // stripes
            default: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
         endcase
      end
   endtask

   // Smallest frame with extremes, saturated magnitudes and flat zero.
   task automatic test_directed_extremes();
      write_csr(sobel_pkg::CsrLineWidth, 13'd3);
      write_csr(sobel_pkg::CsrFrameRows, 13'd3);
      send_frame(3, 3, 3);
      send_frame(3, 3, 1);
      for (int i = 0; i < 9; i++) send_pixel(8'd0);
   endtask

   // Out-of-range registers clamp: width 0 acts as 3, rows 1 acts as 3.
   task automatic test_clamped_registers();
      write_csr(sobel_pkg::CsrLineWidth, 13'd0);
      write_csr(sobel_pkg::CsrFrameRows, 13'd1);
      send_frame(3, 3, 0);
      write_csr(sobel_pkg::CsrLineWidth, 13'h0FFF);   // above MaxLine: acts as 2048
      write_csr(sobel_pkg::CsrFrameRows, 13'd3);
      send_frame(20, 2, 2);   // part of the first row only: no result may appear
   endtask

   // Rows above 4096 clamp; check first rows only then restart via write.
   task automatic test_tall_rows();
      write_csr(sobel_pkg::CsrLineWidth, 13'd3);
      write_csr(sobel_pkg::CsrFrameRows, 13'h1FFF);
      send_frame(3, 6, 0);
   endtask

   // Write mid-frame: position restarts, stores keep their contents.
   task automatic test_mid_frame_restart();
      write_csr(sobel_pkg::CsrLineWidth, 13'd5);
      write_csr(sobel_pkg::CsrFrameRows, 13'd4);
      send_frame(5, 2, 0);
      for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(0, 255)));
      write_csr(sobel_pkg::CsrFrameRows, 13'd4);
      send_frame(5, 4, 0);
   endtask

   // Random small frames, back to back; each register write drains first, as does a pass at 900 to 1000 pixels.
   task automatic test_random_frames();
      int unsigned w, r;
      while (pixels_sent < 1700) begin
         w = $urandom_range(3, 12);
         r = $urandom_range(3, 8);
         write_csr(sobel_pkg::CsrLineWidth, 13'(w));
         write_csr(sobel_pkg::CsrFrameRows, 13'(r));
         repeat ($urandom_range(1, 3)) send_frame(w, r, int'($urandom_range(0, 3)));
         if (pixels_sent > 900 && pixels_sent < 1000) wait_drained();
      end
   endtask

   // Result checker with random back-pressure.
   always @(posedge clock) begin
      edge_result_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_edges.size() == 0) begin
               $error("unexpected result: magnitude %0d", rsp_tdata);
               error_count++;
            end else begin
               exp_res = pending_edges.pop_front();
               if (rsp_tdata !== exp_res.magnitude) begin
                  $error("magnitude: expected %0d, got %0d", exp_res.magnitude, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== exp_res.frame_last) begin
                  $error("frame_last: expected %0b, got %0b", exp_res.frame_last, rsp_tlast);
                  error_count++;
               end
               edges_seen++;
               if (rsp_tlast) frames_seen++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_stall  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = sobel_pkg::CsrLineWidth;
      csr_wdata = '0;
      error_count = 0;
      pixels_sent = 0;
      edges_seen = 0;
      frames_seen = 0;
      width_reg = sobel_pkg::WidthReset;
      rows_reg = sobel_pkg::RowsReset;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = '0;
         win[i][1] = '0;
      end
      for (int i = 0; i < sobel_pkg::MaxLine; i++) begin
         row1_bank[i] = '0;
         row2_bank[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_clamped_registers();
      test_tall_rows();
      test_mid_frame_restart();
      test_random_frames();
      wait_drained();
      $display("Covered %0d pixels, %0d magnitudes, %0d completed frames,",
               pixels_sent, edges_seen, frames_seen);
      $display("with clamped widths and heights and mid-frame restarts.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

### sim.f
sv/sobel_pkg.sv
sv/sobel_ctrl.sv
sv/sobel_dp.sv
sv/sobel_edge_magnitude_top.sv
tb/sobel_edge_magnitude_top_tb.sv
